// ----- rtl/nzs_pkg.sv -----
package nzs_pkg;

	localparam int ZONE_W   = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W    = 6;

	// Coordinates are in 1e-7 degree units
	localparam int DEG_UNITS     = 10000000;
	localparam int HALF_DEG      = 5000000;
	localparam int DEG_W         = 7;          // rounded |lat| in degrees is below 128
	localparam int RECIP_SHIFT   = 54;
	// ceil(2^54 / 1e7): exact floor(x / 1e7) for every x below 2^31
	localparam logic [30:0] DEG_RECIP = 31'd1801439851;
	localparam int DIFF_W        = 34;         // signed coordinate difference
	localparam int MAG_W         = 31;         // magnitude of a difference
	localparam int COS_W         = 16;
	localparam int COS_FRAC      = 15;
	localparam int COS_MAX_DEG   = 90;
	localparam int DIST_W        = 63;

	localparam logic signed [DIFF_W-1:0] HALF_TURN     = 34'sd1800000000;
	localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -HALF_TURN;
	localparam logic signed [DIFF_W-1:0] FULL_TURN     = 34'sd3600000000;

	localparam int NUM_CENTROIDS = 34;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUTO_MODE   = 2'd0,
		REG_MANUAL_ZONE = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OUT_MANUAL = 2'd0,
		OUT_NO_FIX = 2'd1,
		OUT_SAME   = 2'd2,
		OUT_NEW    = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		JOB_MANUAL = 2'd0,
		JOB_NO_FIX = 2'd1,
		JOB_SEARCH = 2'd2
	} job_kind_t;

	typedef struct packed {
		logic signed [30:0] lat_e7;
		logic signed [31:0] lon_e7;
	} in_item_t;

	typedef struct packed {
		logic [ZONE_W-1:0] zone;
		logic [1:0]        outcome;
	} out_item_t;

	typedef struct packed {
		logic              load;      // latch the fix and start a new job
		logic              issue;     // push one centroid into the distance pipe
		logic [ZONE_W-1:0] idx;
		logic              finish;    // write the result transaction
		job_kind_t         kind;
	} nzs_cmd_t;

	typedef struct packed {
		logic fix_zero;
		logic pipe_busy;
		logic out_free;
	} nzs_status_t;

	localparam logic signed [8:0] LAT_TABLE [NUM_CENTROIDS] = '{
		9'sd0, 9'sd38, 9'sd40, 9'sd34, 9'sd38, 9'sd40, 9'sd64, 9'sd21, 9'sd45, 9'sd48, 9'sd19,
		-9'sd23, -9'sd34, -9'sd33, 9'sd4,
		9'sd54, 9'sd50, 9'sd45, 9'sd55, -9'sd29, 9'sd6, -9'sd1,
		9'sd24, 9'sd30, 9'sd22, 9'sd15, 9'sd35, 9'sd1, 9'sd36, 9'sd37,
		-9'sd30, -9'sd25, -9'sd33, -9'sd41
	};

	localparam logic signed [8:0] LON_TABLE [NUM_CENTROIDS] = '{
		9'sd0, -9'sd121, -9'sd110, -9'sd112, -9'sd95, -9'sd77, -9'sd150, -9'sd157,
		-9'sd63, -9'sd56, -9'sd99,
		-9'sd46, -9'sd58, -9'sd71, -9'sd74,
		-9'sd2, 9'sd10, 9'sd25, 9'sd37, 9'sd25, 9'sd3, 9'sd37,
		9'sd54, 9'sd70, 9'sd79, 9'sd101, 9'sd105, 9'sd104, 9'sd138, 9'sd127,
		9'sd120, 9'sd133, 9'sd151, 9'sd174
	};

	localparam logic [COS_W-1:0] COS_TABLE [COS_MAX_DEG+1] = '{
		16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
		16'd32524, 16'd32449, 16'd32365,
		16'd32270, 16'd32166, 16'd32052, 16'd31928, 16'd31795, 16'd31651, 16'd31499,
		16'd31336, 16'd31164, 16'd30983,
		16'd30792, 16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452,
		16'd29197, 16'd28932, 16'd28659,
		16'd28378, 16'd28087, 16'd27789, 16'd27481, 16'd27166, 16'd26842, 16'd26510,
		16'd26169, 16'd25821, 16'd25465,
		16'd25102, 16'd24730, 16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763,
		16'd22348, 16'd21926, 16'd21498,
		16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795, 16'd18324,
		16'd17847, 16'd17364, 16'd16877,
		16'd16384, 16'd15886, 16'd15384, 16'd14876, 16'd14365, 16'd13848, 16'd13328,
		16'd12803, 16'd12275, 16'd11743,
		16'd11207, 16'd10668, 16'd10126, 16'd9580, 16'd9032, 16'd8481, 16'd7927,
		16'd7371, 16'd6813, 16'd6252,
		16'd5690, 16'd5126, 16'd4560, 16'd3993, 16'd3425, 16'd2856, 16'd2286,
		16'd1715, 16'd1144, 16'd572,
		16'd0
	};

	// Centroid latitude in 1e-7 degree; slots past the table hold (0, 0)
	function automatic logic signed [31:0] zone_lat_e7(logic [ZONE_W-1:0] idx);
		logic signed [8:0] d;
		d = (idx < ZONE_W'(NUM_CENTROIDS)) ? LAT_TABLE[idx] : 9'sd0;
		return 32'(d) * 32'sd10000000;
	endfunction

	function automatic logic signed [31:0] zone_lon_e7(logic [ZONE_W-1:0] idx);
		logic signed [8:0] d;
		d = (idx < ZONE_W'(NUM_CENTROIDS)) ? LON_TABLE[idx] : 9'sd0;
		return 32'(d) * 32'sd10000000;
	endfunction

	// Cosine by whole degree, saturated at 90
	function automatic logic [COS_W-1:0] cos_lut(logic [DEG_W-1:0] deg);
		return COS_TABLE[(deg > 7'(COS_MAX_DEG)) ? 7'(COS_MAX_DEG) : deg];
	endfunction

endpackage

// ----- rtl/nzs_ctrl.sv -----
module nzs_ctrl #(
	parameter int NUM_ZONES = 34
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                auto_mode,
	input  nzs_pkg::nzs_status_t status,
	output nzs_pkg::nzs_cmd_t    cmd
);

	localparam int ZW = (NUM_ZONES > 2) ? $clog2(NUM_ZONES) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t              state_q;
	logic [ZW-1:0]       idx_q;
	nzs_pkg::job_kind_t  kind_q;
	logic                accept;
	logic                last_zone;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign last_zone = (idx_q == ZW'(NUM_ZONES - 1));

	always_comb begin
		cmd          = '0;
		cmd.kind     = kind_q;
		cmd.load     = accept;
		cmd.issue    = (state_q == ST_SCAN);
		cmd.idx      = nzs_pkg::ZONE_W'(idx_q);
		cmd.finish   = (state_q == ST_FINISH) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			kind_q  <= nzs_pkg::JOB_MANUAL;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!auto_mode) begin
							kind_q  <= nzs_pkg::JOB_MANUAL;
							state_q <= ST_FINISH;
						end else if (status.fix_zero) begin
							kind_q  <= nzs_pkg::JOB_NO_FIX;
							state_q <= ST_FINISH;
						end else begin
							// cosine is ready before the first centroid reaches the scaler
							kind_q  <= nzs_pkg::JOB_SEARCH;
							idx_q   <= ZW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last_zone) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + ZW'(1);
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/nzs_dpath.sv -----
module nzs_dpath #(
	parameter int NUM_ZONES = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  nzs_pkg::in_item_t             in_data,
	input  logic [nzs_pkg::ZONE_W-1:0]    manual_zone,
	input  logic                          clr_applied,
	input  nzs_pkg::nzs_cmd_t             cmd,
	output nzs_pkg::nzs_status_t          status,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nzs_pkg::out_item_t            out_data
);

	localparam int MW = nzs_pkg::MAG_W;
	localparam int DW = nzs_pkg::DIFF_W;
	localparam int ZN = nzs_pkg::ZONE_W;

	// Latched fix and cosine scale
	logic signed [30:0]             lat_q;
	logic signed [31:0]             lon_q;
	logic [MW-1:0]                  lat_rnd_q;
	logic [2*MW-1:0]                deg_prod_q;
	logic [nzs_pkg::DEG_W-1:0]      lat_deg;
	logic [nzs_pkg::COS_W-1:0]      cos_q;

	// Distance pipe
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [ZN-1:0]          idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6;
	logic signed [DW-1:0]   dlat_s1, dlon_s1;
	logic signed [DW-1:0]   dlon_wrap;
	logic [MW-1:0]          alat_s2, alon_s2;
	logic [2*MW-1:0]        alat_sq_s3, alat_sq_s4, alat_sq_s5;
	logic [MW+nzs_pkg::COS_W-1:0] lprod_s3;
	logic [MW-1:0]          slon_s4;
	logic [2*MW-1:0]        slon_sq_s5;
	logic [nzs_pkg::DIST_W-1:0] dist_s6;

	// Running minimum and zone state
	logic                       first_q;
	logic [nzs_pkg::DIST_W-1:0] best_dist_q;
	logic [ZN-1:0]              best_idx_q;
	logic [ZN-1:0]              current_q;
	logic                       applied_q;
	logic                       out_valid_q;
	nzs_pkg::out_item_t         out_data_q;

	assign lat_deg = deg_prod_q[nzs_pkg::RECIP_SHIFT +: nzs_pkg::DEG_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lat_q     <= in_data.lat_e7;
			lon_q     <= in_data.lon_e7;
			// |lat| + half a degree so the truncating divide rounds half up
			lat_rnd_q <= MW'(in_data.lat_e7[30] ? -32'(in_data.lat_e7) : 32'(in_data.lat_e7))
				+ MW'(nzs_pkg::HALF_DEG);
		end
		// divide by one degree with a reciprocal multiply
		deg_prod_q <= lat_rnd_q * nzs_pkg::DEG_RECIP;
		cos_q      <= nzs_pkg::cos_lut(lat_deg);
	end

	always_comb begin
		priority if (dlon_s1 > nzs_pkg::HALF_TURN) begin
			dlon_wrap = dlon_s1 - nzs_pkg::FULL_TURN;
		end else if (dlon_s1 < nzs_pkg::NEG_HALF_TURN) begin
			dlon_wrap = dlon_s1 + nzs_pkg::FULL_TURN;
		end else begin
			dlon_wrap = dlon_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.idx;
		dlat_s1 <= DW'(lat_q) - DW'(nzs_pkg::zone_lat_e7(cmd.idx));
		dlon_s1 <= DW'(lon_q) - DW'(nzs_pkg::zone_lon_e7(cmd.idx));

		idx_s2  <= idx_s1;
		alat_s2 <= dlat_s1[DW-1] ? MW'(-dlat_s1) : MW'(dlat_s1);
		alon_s2 <= dlon_wrap[DW-1] ? MW'(-dlon_wrap) : MW'(dlon_wrap);

		idx_s3     <= idx_s2;
		alat_sq_s3 <= alat_s2 * alat_s2;
		lprod_s3   <= alon_s2 * cos_q;

		idx_s4     <= idx_s3;
		alat_sq_s4 <= alat_sq_s3;
		slon_s4    <= MW'((($bits(lprod_s3)+1)'(lprod_s3)
			+ ($bits(lprod_s3)+1)'(1 << (nzs_pkg::COS_FRAC - 1))) >> nzs_pkg::COS_FRAC);

		idx_s5     <= idx_s4;
		alat_sq_s5 <= alat_sq_s4;
		slon_sq_s5 <= slon_s4 * slon_s4;

		idx_s6  <= idx_s5;
		dist_s6 <= nzs_pkg::DIST_W'(alat_sq_s5) + nzs_pkg::DIST_W'(slon_sq_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Strict compare in index order keeps the lowest index on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (cmd.load) begin
			first_q <= 1'b1;
		end else if (v_s6 && (first_q || dist_s6 < best_dist_q)) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s6 && (first_q || dist_s6 < best_dist_q)) begin
			best_dist_q <= dist_s6;
			best_idx_q  <= idx_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q   <= '0;
			applied_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (clr_applied) begin
				applied_q <= 1'b0;
			end else if (cmd.finish && cmd.kind == nzs_pkg::JOB_SEARCH &&
				!(applied_q && best_idx_q == current_q)) begin
				applied_q <= 1'b1;
				current_q <= best_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			unique case (cmd.kind)
				nzs_pkg::JOB_MANUAL: begin
					out_data_q.zone    <= (7'(manual_zone) < 7'(NUM_ZONES)) ? manual_zone : '0;
					out_data_q.outcome <= nzs_pkg::OUT_MANUAL;
				end
				nzs_pkg::JOB_NO_FIX: begin
					out_data_q.zone    <= current_q;
					out_data_q.outcome <= nzs_pkg::OUT_NO_FIX;
				end
				nzs_pkg::JOB_SEARCH: begin
					out_data_q.zone <= best_idx_q;
					if (applied_q && best_idx_q == current_q) begin
						out_data_q.outcome <= nzs_pkg::OUT_SAME;
					end else begin
						out_data_q.outcome <= nzs_pkg::OUT_NEW;
					end
				end
				default: begin
					out_data_q.zone    <= current_q;
					out_data_q.outcome <= nzs_pkg::OUT_NO_FIX;
				end
			endcase
		end
	end

	assign status.fix_zero  = (in_data.lat_e7 == '0) && (in_data.lon_e7 == '0);
	assign status.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
	assign status.out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ----- rtl/nearest_zone_selector.sv -----
// Nearest zone selector.
// Input channel (in_valid / in_stall / in_data) carries one position fix per
// transaction: latitude and longitude in 1e-7 degree. Output channel
// (out_valid / out_stall / out_data) returns one transaction per fix: the
// zone index and an outcome code (manual, no fix, unchanged, new zone).
// Config port: cfg_we / cfg_index / cfg_wdata. Index 0 is auto_mode (writing
// it clears the applied flag), index 1 is manual_zone; other indexes are
// dropped. Write only while the block is idle.
// A search issues one centroid per cycle into a 6-stage distance pipe
// (NUM_ZONES-1 zones), drains it and then writes the result. The cosine
// degree comes from a reciprocal multiply that finishes while the first
// centroids are in flight. Manual mode and an all-zero fix go from the
// accept straight to the finish state, which writes the output register
// once it is free. One fix at a time: the next fix is taken only after
// the result is written.
// in_stall is high from the accept until the result is written to the output
// register, so a result waiting on out_stall still holds off the next fix
// only until it is taken; the output register holds its transaction stable
// while out_stall is high.
// Reset clears the control state, the current zone (0), the applied flag, and
// sets auto_mode to 1 and manual_zone to 0.
module nearest_zone_selector #(
	parameter int NUM_ZONES = 34
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  nzs_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nzs_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [nzs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nzs_pkg::CFG_W-1:0]     cfg_wdata
);

	logic                          auto_mode_q;
	logic [nzs_pkg::ZONE_W-1:0]    manual_zone_q;
	logic                          clr_applied;
	nzs_pkg::nzs_cmd_t             cmd;
	nzs_pkg::nzs_status_t          status;

	// Any write to the mode register forces the next search to apply its zone
	assign clr_applied = cfg_we && (cfg_index == nzs_pkg::REG_AUTO_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q   <= 1'b1;
			manual_zone_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nzs_pkg::REG_AUTO_MODE:   auto_mode_q   <= cfg_wdata[0];
				nzs_pkg::REG_MANUAL_ZONE: manual_zone_q <= cfg_wdata[nzs_pkg::ZONE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer: accept, scan the centroids, drain, write the result
	nzs_ctrl #(
		.NUM_ZONES (NUM_ZONES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.auto_mode (auto_mode_q),
		.status    (status),
		.cmd       (cmd)
	);

	// Distance pipe, running minimum, zone state and output register
	nzs_dpath #(
		.NUM_ZONES (NUM_ZONES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.manual_zone (manual_zone_q),
		.clr_applied (clr_applied),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

// ----- rtl/nzs_checker.sv -----
module nzs_checker #(
	parameter int NUM_ZONES = 34
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input nzs_pkg::out_item_t  out_data
);

	// One fix in flight: an accepted transaction closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while a fix is in flight");

	// A result only appears after the block was busy with a fix
	a_result_follows_fix: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a fix in flight");

	a_zone_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (7'(out_data.zone) < 7'(NUM_ZONES)))
		else $error("zone index out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind nearest_zone_selector nzs_checker #(
	.NUM_ZONES (NUM_ZONES)
) u_nzs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
